FILE: hw/rtl/pdl_pkg.sv
package pdl_pkg;

   // item kinds carried in tuser
   localparam logic [1:0] MODE_LOAD   = 2'd0;
   localparam logic [1:0] MODE_PRIME  = 2'd1;
   localparam logic [1:0] MODE_RENDER = 2'd2;

   // table selects for load transactions
   localparam logic [3:0] SEL_LUMA_LO  = 4'd0;
   localparam logic [3:0] SEL_LUMA_HI  = 4'd1;
   localparam logic [3:0] SEL_U_EVEN   = 4'd2;
   localparam logic [3:0] SEL_V_EVEN   = 4'd3;
   localparam logic [3:0] SEL_U_ODD    = 4'd4;
   localparam logic [3:0] SEL_V_ODD    = 4'd5;
   localparam logic [3:0] SEL_GAMMA_R  = 4'd6;
   localparam logic [3:0] SEL_GAMMA_G  = 4'd7;
   localparam logic [3:0] SEL_GAMMA_B  = 4'd8;

   // register indexes
   localparam logic CSR_GAIN  = 1'b0;
   localparam logic CSR_ALPHA = 1'b1;

   localparam int          DEF_LINE_WIDTH = 1024;
   localparam logic [5:0]  EVEN_GAIN      = 6'd32;
   localparam logic [5:0]  GAIN_RESET     = 6'd32;
   localparam int          PAL_ENTRIES    = 256;
   localparam int          GAMMA_ENTRIES  = 768;
   localparam int          GAMMA_OFFSET   = 256;

   // fields that ride along every stage
   typedef struct packed {
      logic [1:0]  mode;
      logic [3:0]  sel;
      logic [9:0]  addr;
      logic [31:0] data;
      logic [9:0]  column;
      logic        odd;
   } ctl_type;

   typedef struct packed {
      ctl_type     ctl;
      logic [31:0] luma;
      logic [31:0] us;
      logic [31:0] vs;
      logic [31:0] du;
      logic [31:0] dv;
   } fetch_out_type;

   typedef struct packed {
      ctl_type     ctl;
      logic [31:0] gr_sum;
      logic [9:0]  r_idx;
      logic [9:0]  b_idx;
   } mat_out_type;

   // 256 + (x >> 16), clamped to the gamma table range
   function automatic logic [9:0] gamma_index(input logic [15:0] chan);
      logic signed [16:0] s;
      s = $signed({chan[15], chan}) + 17'sd256;
      if (s < 17'sd0)
         return 10'd0;
      else if (s > 17'sd767)
         return 10'd767;
      else
         return s[9:0];
   endfunction

endpackage

FILE: hw/rtl/pdl_fetch.sv
module pdl_fetch import pdl_pkg::*; #(
   parameter int LINE_WIDTH = DEF_LINE_WIDTH
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  ctl_type       in_ctl,
   input  logic [7:0]    pix_a,
   input  logic [7:0]    pix_b,
   input  logic [7:0]    pix_c,
   input  logic [7:0]    pix_d,
   output logic          out_valid,
   input  logic          out_ready,
   output fetch_out_type out_data
);

   localparam int SLOT_W  = (LINE_WIDTH > 1) ? $clog2(LINE_WIDTH) : 1;
   localparam int RECIP   = (1 << 20) / LINE_WIDTH;

   // palette tables; copies give one read port per window tap
   logic [31:0] luma_lo_mem [2][PAL_ENTRIES];
   logic [31:0] luma_hi_mem [PAL_ENTRIES];
   logic [31:0] chroma_u_mem [4][2*PAL_ENTRIES];
   logic [31:0] chroma_v_mem [4][2*PAL_ENTRIES];
   logic [63:0] delay_mem [LINE_WIDTH];

   logic        s1_valid_ff, s2_valid_ff;
   logic        en1, en2;
   ctl_type     s1_ctl_ff;
   logic [9:0]  s1_q_ff;
   logic [9:0]  q_in;
   logic [29:0] q_prod;
   logic [31:0] lo_rd_ff [2];
   logic [31:0] hi_rd_ff;
   logic [31:0] u_rd_ff [4];
   logic [31:0] v_rd_ff [4];
   logic [7:0]  pix [4];
   logic        acc, low_addr, we_lo, we_hi, we_u, we_v;
   logic [8:0]  chroma_waddr;
   logic [31:0] luma_in, us_in, vs_in;
   logic [22:0] rem;
   logic [SLOT_W-1:0] slot;
   logic        dly_we;
   fetch_out_type s2_ff;

   assign en1      = !s1_valid_ff || en2;
   assign en2      = !s2_valid_ff || out_ready;
   assign in_ready = en1;
   assign acc      = in_valid && en1;

   assign pix[0] = pix_a;
   assign pix[1] = pix_b;
   assign pix[2] = pix_c;
   assign pix[3] = pix_d;

   // table write decode
   assign low_addr     = (in_ctl.addr < 10'(PAL_ENTRIES));
   assign we_lo        = acc && in_ctl.mode == MODE_LOAD && low_addr && in_ctl.sel == SEL_LUMA_LO;
   assign we_hi        = acc && in_ctl.mode == MODE_LOAD && low_addr && in_ctl.sel == SEL_LUMA_HI;
   assign we_u         = acc && in_ctl.mode == MODE_LOAD && low_addr &&
                         (in_ctl.sel == SEL_U_EVEN || in_ctl.sel == SEL_U_ODD);
   assign we_v         = acc && in_ctl.mode == MODE_LOAD && low_addr &&
                         (in_ctl.sel == SEL_V_EVEN || in_ctl.sel == SEL_V_ODD);
   assign chroma_waddr = {(in_ctl.sel == SEL_U_ODD || in_ctl.sel == SEL_V_ODD),
                          in_ctl.addr[7:0]};

   // coarse column quotient for the delay-line slot
   assign q_prod = 30'(in_ctl.column) * 30'(RECIP);
   assign q_in   = q_prod[29:20];

   // stage 1: table access
   always_ff @(posedge clock) begin
      for (int k = 0; k < 2; k++) begin
         if (we_lo) luma_lo_mem[k][in_ctl.addr[7:0]] <= in_ctl.data;
      end
      if (we_hi) luma_hi_mem[in_ctl.addr[7:0]] <= in_ctl.data;
      for (int k = 0; k < 4; k++) begin
         if (we_u) chroma_u_mem[k][chroma_waddr] <= in_ctl.data;
         if (we_v) chroma_v_mem[k][chroma_waddr] <= in_ctl.data;
      end
      if (en1) begin
         s1_ctl_ff   <= in_ctl;
         s1_q_ff     <= q_in;
         lo_rd_ff[0] <= luma_lo_mem[0][pix_b];
         lo_rd_ff[1] <= luma_lo_mem[1][pix_d];
         hi_rd_ff    <= luma_hi_mem[pix_c];
         for (int k = 0; k < 4; k++) begin
            u_rd_ff[k] <= chroma_u_mem[k][{in_ctl.odd, pix[k]}];
            v_rd_ff[k] <= chroma_v_mem[k][{in_ctl.odd, pix[k]}];
         end
      end
   end

   // stage 2 sums and slot
   always_comb begin
      luma_in = lo_rd_ff[0] + hi_rd_ff + lo_rd_ff[1];
      us_in   = u_rd_ff[0] + u_rd_ff[1] + u_rd_ff[2] + u_rd_ff[3];
      vs_in   = v_rd_ff[0] + v_rd_ff[1] + v_rd_ff[2] + v_rd_ff[3];
      rem     = 23'(s1_ctl_ff.column) - 23'(s1_q_ff) * 23'(LINE_WIDTH);
      if (rem >= 23'(LINE_WIDTH))
         rem = rem - 23'(LINE_WIDTH);
      slot    = rem[SLOT_W-1:0];
      dly_we  = en2 && s1_valid_ff &&
                (s1_ctl_ff.mode == MODE_PRIME || s1_ctl_ff.mode == MODE_RENDER);
   end

   // stage 2: delay line read then overwrite
   always_ff @(posedge clock) begin
      if (dly_we) delay_mem[slot] <= {vs_in, us_in};
      if (en2) begin
         {s2_ff.dv, s2_ff.du} <= delay_mem[slot];
         s2_ff.ctl   <= s1_ctl_ff;
         s2_ff.luma  <= luma_in;
         s2_ff.us    <= us_in;
         s2_ff.vs    <= vs_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (en1) s1_valid_ff <= in_valid;
         if (en2) s2_valid_ff <= s1_valid_ff;
      end
   end

   assign out_data  = s2_ff;
   assign out_valid = s2_valid_ff;

endmodule

FILE: hw/rtl/pdl_matrix.sv
module pdl_matrix import pdl_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic [5:0]    odd_gain,
   input  logic          in_valid,
   output logic          in_ready,
   input  fetch_out_type in_data,
   output logic          out_valid,
   input  logic          out_ready,
   output mat_out_type   out_data
);

   logic        v3_ff, v4_ff, v5_ff, v6_ff;
   logic        en3, en4, en5, en6;
   ctl_type     c3_ff, c4_ff, c5_ff, c6_ff;
   logic [31:0] l3_ff, l4_ff, l5_ff;
   logic [31:0] su_ff, sv_ff;
   logic [5:0]  g_ff;
   logic [31:0] u_ff, v_ff;
   logic [31:0] p_ff, rs_ff, bs_ff;
   logic [31:0] gt_ff;
   logic [9:0]  ri_ff, bi_ff;
   logic [31:0] p_shift;

   assign en6      = !v6_ff || out_ready;
   assign en5      = !v5_ff || en6;
   assign en4      = !v4_ff || en5;
   assign en3      = !v3_ff || en4;
   assign in_ready = en3;

   assign p_shift = {{8{p_ff[31]}}, p_ff[31:8]};

   always_ff @(posedge clock) begin
      // stage 3: add delay line, pick gain
      if (en3) begin
         c3_ff <= in_data.ctl;
         l3_ff <= in_data.luma;
         su_ff <= in_data.us + in_data.du;
         sv_ff <= in_data.vs + in_data.dv;
         g_ff  <= in_data.ctl.odd ? odd_gain : EVEN_GAIN;
      end
      // stage 4: chroma gain
      if (en4) begin
         c4_ff <= c3_ff;
         l4_ff <= l3_ff;
         u_ff  <= 32'(su_ff * 32'(g_ff));
         v_ff  <= 32'(sv_ff * 32'(g_ff));
      end
      // stage 5: green mix and red/blue sums
      if (en5) begin
         c5_ff <= c4_ff;
         l5_ff <= l4_ff;
         p_ff  <= 32'(u_ff * 32'd50) + 32'(v_ff * 32'd130);
         rs_ff <= l4_ff + v_ff;
         bs_ff <= l4_ff + u_ff;
      end
      // stage 6: green difference, red/blue gamma indexes
      if (en6) begin
         c6_ff <= c5_ff;
         gt_ff <= l5_ff - p_shift;
         ri_ff <= gamma_index(rs_ff[31:16]);
         bi_ff <= gamma_index(bs_ff[31:16]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         if (en3) v3_ff <= in_valid;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
         if (en6) v6_ff <= v5_ff;
      end
   end

   assign out_valid       = v6_ff;
   assign out_data.ctl    = c6_ff;
   assign out_data.gr_sum = gt_ff;
   assign out_data.r_idx  = ri_ff;
   assign out_data.b_idx  = bi_ff;

endmodule

FILE: hw/rtl/pdl_gamma.sv
module pdl_gamma import pdl_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic [31:0]  alpha,
   input  logic         in_valid,
   output logic         in_ready,
   input  mat_out_type  in_data,
   output logic         out_valid,
   input  logic         out_ready,
   output logic [31:0]  out_word,
   output logic [9:0]   out_column
);

   logic [31:0] gamma_r_mem [GAMMA_ENTRIES];
   logic [31:0] gamma_g_mem [GAMMA_ENTRIES];
   logic [31:0] gamma_b_mem [GAMMA_ENTRIES];

   logic        v7_ff, en7, en8, out_valid_ff;
   logic        render7_ff;
   logic [9:0]  col7_ff;
   logic [31:0] r_rd_ff, g_rd_ff, b_rd_ff;
   logic [31:0] word_ff;
   logic [9:0]  col_ff;
   logic [9:0]  g_idx;
   logic        load, addr_ok;
   logic        we_r, we_g, we_b;

   assign en8      = !out_valid_ff || out_ready;
   assign en7      = !v7_ff || en8;
   assign in_ready = en7;

   assign g_idx   = gamma_index(in_data.gr_sum[31:16]);
   assign load    = en7 && in_valid && in_data.ctl.mode == MODE_LOAD;
   assign addr_ok = in_data.ctl.addr < 10'(GAMMA_ENTRIES);
   assign we_r    = load && addr_ok && in_data.ctl.sel == SEL_GAMMA_R;
   assign we_g    = load && addr_ok && in_data.ctl.sel == SEL_GAMMA_G;
   assign we_b    = load && addr_ok && in_data.ctl.sel == SEL_GAMMA_B;

   // stage 7: gamma lookup, loads written in stream order
   always_ff @(posedge clock) begin
      if (we_r) gamma_r_mem[in_data.ctl.addr] <= in_data.ctl.data;
      if (we_g) gamma_g_mem[in_data.ctl.addr] <= in_data.ctl.data;
      if (we_b) gamma_b_mem[in_data.ctl.addr] <= in_data.ctl.data;
      if (en7) begin
         r_rd_ff    <= gamma_r_mem[in_data.r_idx];
         g_rd_ff    <= gamma_g_mem[g_idx];
         b_rd_ff    <= gamma_b_mem[in_data.b_idx];
         render7_ff <= in_data.ctl.mode == MODE_RENDER;
         col7_ff    <= in_data.ctl.column;
      end
   end

   // stage 8: output register
   always_ff @(posedge clock) begin
      if (en8) begin
         word_ff <= r_rd_ff | g_rd_ff | b_rd_ff | alpha;
         col_ff  <= col7_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (en7) v7_ff <= in_valid;
         if (en8) out_valid_ff <= v7_ff && render7_ff;
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_word   = word_ff;
   assign out_column = col_ff;

endmodule

FILE: hw/rtl/pal_delay_line_color_render.sv
// PAL delay-line color renderer. One transaction per clock is accepted in
// steady state while the response side is not stalled by rsp_tready.
// Load transactions fill the luma, chroma and gamma tables, prime
// transactions store chroma sums into the per-column delay line, and render
// transactions produce one RGBA word each. Every table is accessed at one
// pipeline stage by both loads and renders, so all accesses take effect in
// stream order; the palette tables are kept in several copies so each window
// tap has its own read port. Tables and the delay line have no reset value
// and must be loaded before use. The odd-line gain and alpha registers may
// only be written while the pipeline is empty.
module pal_delay_line_color_render import pdl_pkg::*; #(
   parameter int LINE_WIDTH = DEF_LINE_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // table_addr, table_data, pix_a, pix_b, pix_c, pix_d, column, zero fill
   input  logic [87:0] req_tdata,
   // mode, table_select, line_odd
   input  logic [6:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // rgba_word, out_column, zero fill
   output logic [47:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);

   logic [5:0]    gain_ff;
   logic [31:0]   alpha_ff;
   ctl_type       in_ctl;
   logic          f_valid, f_ready, m_valid, m_ready;
   fetch_out_type f_data;
   mat_out_type   m_data;
   logic [31:0]   word;
   logic [9:0]    col;

   // configuration registers
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff  <= GAIN_RESET;
         alpha_ff <= 32'd0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_GAIN:  gain_ff  <= csr_data[5:0];
            CSR_ALPHA: alpha_ff <= csr_data;
            default:   ;
         endcase
      end
   end

   assign in_ctl.mode   = req_tuser[1:0];
   assign in_ctl.sel    = req_tuser[5:2];
   assign in_ctl.odd    = req_tuser[6];
   assign in_ctl.addr   = req_tdata[9:0];
   assign in_ctl.data   = req_tdata[41:10];
   assign in_ctl.column = req_tdata[83:74];

   pdl_fetch #(.LINE_WIDTH(LINE_WIDTH)) u_fetch (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_ctl    (in_ctl),
      .pix_a     (req_tdata[49:42]),
      .pix_b     (req_tdata[57:50]),
      .pix_c     (req_tdata[65:58]),
      .pix_d     (req_tdata[73:66]),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_data  (f_data)
   );

   pdl_matrix u_matrix (
      .clock     (clock),
      .reset     (reset),
      .odd_gain  (gain_ff),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_data   (f_data),
      .out_valid (m_valid),
      .out_ready (m_ready),
      .out_data  (m_data)
   );

   pdl_gamma u_gamma (
      .clock      (clock),
      .reset      (reset),
      .alpha      (alpha_ff),
      .in_valid   (m_valid),
      .in_ready   (m_ready),
      .in_data    (m_data),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_word   (word),
      .out_column (col)
   );

   assign rsp_tdata = {6'd0, col, word};

endmodule

FILE: hw/rtl/pdl_checker.sv
module pdl_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata
);

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // an empty output register never blocks the request side
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled with empty output");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

endmodule

bind pal_delay_line_color_render pdl_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

FILE: tb/tb_pal_delay_line_color_render.sv
`timescale 1ns / 1ps

module tb_pal_delay_line_color_render;
   import pdl_pkg::*;

   localparam logic [1:0] MODE_NONE  = 2'd3;
   localparam int         WATCH_MAX  = 5000;
   localparam int         DRAIN_WAIT = 12;
   localparam int         HOLD_LEN   = 400;

   typedef struct {
      logic [1:0]  mode;
      logic [3:0]  sel;
      logic [9:0]  addr;
      logic [31:0] data;
      logic [7:0]  pa, pb, pc, pd;
      logic [9:0]  column;
      logic        odd;
   } pix_item_type;

   typedef struct {
      logic [31:0] rgba;
      logic [9:0]  column;
   } pixel_out_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [87:0] req_tdata = '0;
   logic [6:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = 1'b0;
   logic [31:0] csr_data = '0;

   pal_delay_line_color_render uut (.*);

   always #6 clock = ~clock;

   // predictor state
   logic [31:0] luma_lo [256];
   logic [31:0] luma_hi [256];
   logic [31:0] chroma  [1024];
   logic [31:0] gamma   [2304];
   logic [31:0] line_u  [1024];
   logic [31:0] line_v  [1024];
   logic [5:0]  gain_reg = GAIN_RESET;
   logic [31:0] alpha_reg = '0;

   pix_item_type  pending[$];
   pixel_out_type pixels_due[$];
   int         send_idle = 0;
   int         recv_stall = 0;
   bit         hold_req = 0;
   int         errors = 0;
   bit         primed [1024];

   function automatic logic [9:0] clamp_idx(input logic signed [31:0] chan);
      int idx;
      idx = 256 + chan;
      if (idx < 0) idx = 0;
      if (idx > 767) idx = 767;
      return idx[9:0];
   endfunction

   function automatic void window_sums(input pix_item_type it, output logic [31:0] us,
                                       output logic [31:0] vs);
      int base;
      base = it.odd ? 512 : 0;
      us = chroma[base + it.pa] + chroma[base + it.pb] + chroma[base + it.pc]
           + chroma[base + it.pd];
      vs = chroma[base + 256 + it.pa] + chroma[base + 256 + it.pb]
           + chroma[base + 256 + it.pc] + chroma[base + 256 + it.pd];
   endfunction

   // apply one accepted transaction to the predictor
   task automatic apply_item(input pix_item_type it);
      logic [31:0] us, vs, l, u, v, g, t, d;
      logic signed [31:0] sh;
      pixel_out_type px;
      case (it.mode)
         MODE_LOAD: begin
            if (it.sel <= SEL_V_ODD) begin
               if (it.addr < 256) begin
                  if (it.sel == SEL_LUMA_LO) luma_lo[it.addr] = it.data;
                  else if (it.sel == SEL_LUMA_HI) luma_hi[it.addr] = it.data;
                  else chroma[(it.sel - SEL_U_EVEN) * 256 + it.addr] = it.data;
               end
            end else if (it.sel <= SEL_GAMMA_B && it.addr < 768) begin
               gamma[(it.sel - SEL_GAMMA_R) * 768 + it.addr] = it.data;
            end
         end
         MODE_PRIME: begin
            window_sums(it, us, vs);
            line_u[it.column] = us;
            line_v[it.column] = vs;
         end
         MODE_RENDER: begin
            l = luma_lo[it.pb] + luma_hi[it.pc] + luma_lo[it.pd];
            window_sums(it, us, vs);
            g = it.odd ? {26'd0, gain_reg} : 32'd32;
            u = (us + line_u[it.column]) * g;
            v = (vs + line_v[it.column]) * g;
            line_u[it.column] = us;
            line_v[it.column] = vs;
            t = 32'd50 * u + 32'd130 * v;
            sh = $signed(t) >>> 8;
            d = l - sh;
            px.rgba = gamma[clamp_idx($signed(l + v) >>> 16)]
                      | gamma[768 + clamp_idx($signed(d) >>> 16)]
                      | gamma[1536 + clamp_idx($signed(l + u) >>> 16)] | alpha_reg;
            px.column = it.column;
            pixels_due.push_back(px);
         end
         default: ;
      endcase
   endtask

   // driver
   always @(posedge clock) begin
      pix_item_type it;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            it.mode = req_tuser[1:0];  it.sel = req_tuser[5:2];  it.odd = req_tuser[6];
            {it.column, it.pd, it.pc, it.pb, it.pa, it.data, it.addr} = req_tdata[83:0];
            apply_item(it);
         end
         if (!(req_tvalid && !req_tready)) begin
            if (pending.size() > 0 && $urandom_range(99) >= send_idle) begin
               it = pending.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {4'd0, it.column, it.pd, it.pc, it.pb, it.pa, it.data, it.addr};
               req_tuser <= {it.odd, it.sel, it.mode};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor and checker
   int hold_cnt = 0;
   always @(posedge clock) begin
      pixel_out_type px;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pixels_due.size() == 0) begin
               $error("unexpected pixel: rgba_word %h out_column %0d",
                      rsp_tdata[31:0], rsp_tdata[41:32]);
               errors++;
            end else begin
               px = pixels_due.pop_front();
               if (rsp_tdata[31:0] !== px.rgba) begin
                  $error("rgba_word: expected %h actual %h", px.rgba, rsp_tdata[31:0]);
                  errors++;
               end
               if (rsp_tdata[41:32] !== px.column) begin
                  $error("out_column: expected %0d actual %0d", px.column,
                         rsp_tdata[41:32]);
                  errors++;
               end
            end
         end
         if (hold_req) begin
            hold_req = 0;
            hold_cnt = HOLD_LEN;
         end
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall);
         end
      end
   end

   // watchdog: cycles without any transaction
   int quiet = 0;
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready))
         quiet <= 0;
      else if (quiet >= WATCH_MAX) begin
         $display("FAILED: results differ");
         $finish;
      end else
         quiet <= quiet + 1;
   end

   task automatic write_reg(input logic idx, input logic [31:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_GAIN) gain_reg = val[5:0];
      else alpha_reg = val;
   endtask

   task automatic drain();
      do @(posedge clock);
      while (pending.size() > 0 || req_tvalid || pixels_due.size() > 0);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_word();
      int s;
      if ($urandom_range(3) == 0) return $urandom;
      s = int'($urandom_range(0, 262143)) - 131072;
      return s;
   endfunction

   function automatic pix_item_type load_item(input logic [3:0] sel, input logic [9:0] addr,
                                              input logic [31:0] data);
      pix_item_type it;
      it.mode = MODE_LOAD;  it.sel = sel;  it.addr = addr;  it.data = data;
      it.pa = 8'($urandom);  it.pb = 8'($urandom);  it.pc = 8'($urandom);
      it.pd = 8'($urandom);
      it.column = 10'($urandom);  it.odd = 1'($urandom);
      return it;
   endfunction

   // window item; a render to an unprimed column gets a prime first
   task automatic push_window(input logic [1:0] mode, input logic [9:0] col,
                              input logic odd, input logic [7:0] a, input logic [7:0] b,
                              input logic [7:0] c, input logic [7:0] d);
      pix_item_type it;
      if (mode == MODE_RENDER && !primed[col])
         push_window(MODE_PRIME, col, 1'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom), 8'($urandom));
      it.mode = mode;  it.sel = 4'($urandom);  it.addr = 10'($urandom);
      it.data = $urandom;
      it.pa = a;  it.pb = b;  it.pc = c;  it.pd = d;  it.column = col;  it.odd = odd;
      if (mode == MODE_PRIME || mode == MODE_RENDER) primed[col] = 1;
      pending.push_back(it);
   endtask

   // random window item of the given kind
   task automatic push_random(input logic [1:0] mode);
      push_window(mode, 10'($urandom), 1'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom), 8'($urandom));
   endtask

   task automatic random_item();
      int pick;
      logic [3:0] sel;
      pick = $urandom_range(99);
      if (pick < 12) begin
         sel = 4'($urandom_range(0, 8));
         pending.push_back(load_item(sel,
                                     10'($urandom_range(0, sel <= SEL_V_ODD ? 255 : 767)),
                                     sel >= SEL_GAMMA_R ? $urandom : rand_word()));
      end else if (pick < 15) begin
         pending.push_back(load_item(4'($urandom), 10'($urandom), $urandom));
      end else if (pick < 28) begin
         push_random(MODE_PRIME);
      end else if (pick < 31) begin
         push_random(MODE_NONE);
      end else begin
         push_random(MODE_RENDER);
      end
   endtask

   initial begin
      logic [3:0] sel;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // phase 0: no idling, extremes low
      write_reg(CSR_GAIN, 32'd0);
      write_reg(CSR_ALPHA, 32'd0);

      // fill every table so no read hits an unwritten entry
      for (int i = 0; i < 256; i++) begin
         pending.push_back(load_item(SEL_LUMA_LO, 10'(i), rand_word()));
         pending.push_back(load_item(SEL_LUMA_HI, 10'(i), rand_word()));
         for (sel = SEL_U_EVEN; sel <= SEL_V_ODD; sel++)
            pending.push_back(load_item(sel, 10'(i), rand_word()));
      end
      for (int i = 0; i < 768; i++)
         for (sel = SEL_GAMMA_R; sel <= SEL_GAMMA_B; sel++)
            pending.push_back(load_item(sel, 10'(i), $urandom));

      // directed: extremes, loads beyond tables, unknown table and mode
      pending.push_back(load_item(SEL_LUMA_LO, 10'd256, 32'hFFFF_FFFF));
      pending.push_back(load_item(SEL_V_ODD, 10'd1023, 32'h0));
      pending.push_back(load_item(SEL_GAMMA_B, 10'd768, 32'hFFFF_FFFF));
      pending.push_back(load_item(4'd9, 10'd5, 32'hFFFF_FFFF));
      pending.push_back(load_item(4'd15, 10'd1023, 32'hFFFF_FFFF));
      pending.push_back(load_item(SEL_LUMA_HI, 10'd255, 32'h7FFF_FFFF));
      pending.push_back(load_item(SEL_GAMMA_G, 10'd767, 32'h8000_0000));
      push_window(MODE_PRIME, 10'd0, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0);
      push_window(MODE_PRIME, 10'd1023, 1'b1, 8'd255, 8'd255, 8'd255, 8'd255);
      push_window(MODE_RENDER, 10'd0, 1'b0, 8'd255, 8'd255, 8'd255, 8'd255);
      push_window(MODE_RENDER, 10'd1023, 1'b1, 8'd0, 8'd0, 8'd0, 8'd0);
      push_window(MODE_RENDER, 10'd0, 1'b1, 8'd0, 8'd255, 8'd0, 8'd255);
      push_window(MODE_RENDER, 10'd1023, 1'b0, 8'd255, 8'd0, 8'd255, 8'd0);
      push_window(MODE_NONE, 10'd1023, 1'b1, 8'd255, 8'd255, 8'd255, 8'd255);
      push_window(MODE_RENDER, 10'd512, 1'b1, 8'd1, 8'd2, 8'd3, 8'd4);
      push_window(MODE_RENDER, 10'd512, 1'b0, 8'd170, 8'd85, 8'd170, 8'd85);
      drain();

      // random phases, each with its own register setting and idling
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin
               send_idle = 83;  recv_stall = 0;
               write_reg(CSR_GAIN, 32'd63);
               write_reg(CSR_ALPHA, 32'hFFFF_FFFF);
            end
            2: begin
               send_idle = 0;  recv_stall = 83;
               write_reg(CSR_GAIN, $urandom_range(1, 62));
               write_reg(CSR_ALPHA, $urandom);
            end
            default: begin
               send_idle = 12;  recv_stall = 12;
               write_reg(CSR_GAIN, 32'd32);
               write_reg(CSR_ALPHA, $urandom & 32'hFF00_0000);
            end
         endcase
         // long receiver hold while the sender keeps offering
         if (ph == 0) hold_req = 1;
         for (int i = 0; i < 175; i++) begin
            random_item();
            // sender pauses once until every pixel is out
            if (ph == 3 && i == 80) drain();
         end
         drain();
      end

      if (errors == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
